// ----- src/lococ_pkg.sv -----
// Shared types and status codes for the lock order cycle checker.
package lococ_pkg;

    typedef struct packed {
        logic       kind;
        logic [4:0] lock_id;
    } lococ_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] cycle_from;
        logic [4:0] cycle_to;
        logic [4:0] held_depth;
    } lococ_out_t;

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NEW_EDGE     = 3'd1;
    localparam logic [2:0] ST_DEADLOCK     = 3'd2;
    localparam logic [2:0] ST_MULTI_UNLOCK = 3'd3;
    localparam logic [2:0] ST_BAD_UNLOCK   = 3'd4;
    localparam logic [2:0] ST_OVERFLOW     = 3'd5;
    localparam logic [2:0] ST_HALTED       = 3'd6;

endpackage

// ----- src/lococ_matrix.sv -----
// Lock order adjacency matrix: one row per lock, per-row valid bits cleared at reset.
module lococ_matrix import lococ_pkg::*; #(
    parameter int MAX_LOCKS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [$clog2(MAX_LOCKS)-1:0] rd_addr,
    output logic [MAX_LOCKS-1:0]         rd_row,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_LOCKS)-1:0] wr_addr,
    input  logic [MAX_LOCKS-1:0]         wr_row
);

    logic [MAX_LOCKS-1:0] mem [MAX_LOCKS];
    logic [MAX_LOCKS-1:0] row_valid_reg;
    logic [MAX_LOCKS-1:0] rdata_reg;
    logic                 rvalid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end else begin
            if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            rvalid_reg <= row_valid_reg[rd_addr];
        end
    end

    // a row never written reads as no edges
    assign rd_row = rvalid_reg ? rdata_reg : '0;

endmodule

// ----- src/lock_order_cycle_checker_top.sv -----
// Lock order cycle checker: held-lock stack, order matrix and depth-first cycle search.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_data (kind, lock_id)
//   m_      | out       | m_valid / m_ready  | m_data (status, cycle_from, cycle_to, held_depth)
//
// An acquire that meets a known edge just pushes its lock; one that adds a new edge starts a
// search that reads the matrix one row at a time through its single read port. One event is
// in flight at a time; a result waits in the output register.
// Reset is synchronous and clears the matrix row valid bits at once; no clearing pass.
module lock_order_cycle_checker_top import lococ_pkg::*; #(
    parameter int MAX_LOCKS   = 32,
    parameter int STACK_DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  lococ_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output lococ_out_t m_data
);

    localparam int LW  = $clog2(MAX_LOCKS);
    localparam int CW  = $clog2(MAX_LOCKS + 1);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int HCW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TOP  = 3'd1;
    localparam logic [2:0] S_EDGE = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_POP  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    typedef struct packed {
        logic [LW-1:0] node;
        logic [CW-1:0] cur;
    } walk_t;

    logic [2:0]           state_reg, state_next;
    logic                 kind_reg, kind_next;
    logic [4:0]           id_reg, id_next;
    logic [HCW-1:0]       held_count_reg, held_count_next;
    logic                 halted_reg, halted_next;
    logic [LW-1:0]        prev_reg, prev_next;
    logic [MAX_LOCKS-1:0] seen_reg, seen_next;
    logic [MAX_LOCKS-1:0] done_reg, done_next;
    logic [LW-1:0]        top_node_reg, top_node_next;
    logic [CW-1:0]        top_cur_reg, top_cur_next;
    logic [CW-1:0]        sp_reg, sp_next;
    lococ_out_t           res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    lococ_out_t           m_data_reg, m_data_next;

    // held stack memory
    logic [4:0]    held_mem [STACK_DEPTH];
    logic [4:0]    hs_rdata_reg;
    logic [SW-1:0] hs_raddr;
    logic          hs_we;

    // walk stack memory
    walk_t         walk_mem [MAX_LOCKS];
    walk_t         walk_rdata_reg;
    logic [LW-1:0] walk_raddr;
    logic          walk_we;
    walk_t         walk_wdata;

    logic [LW-1:0]        mx_raddr;
    logic [MAX_LOCKS-1:0] mx_row;
    logic                 mx_we;
    logic [MAX_LOCKS-1:0] mx_wrow;

    logic [LW-1:0]        id_node;
    logic                 id_out_of_range;
    logic [HCW-1:0]       count_m1;
    logic [MAX_LOCKS-1:0] avail;
    logic                 t_found;
    logic [LW-1:0]        t_idx;
    logic                 r_found;
    logic [LW-1:0]        r_idx;

    lococ_matrix #(.MAX_LOCKS(MAX_LOCKS)) u_matrix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (mx_raddr),
        .rd_row  (mx_row),
        .wr_en   (mx_we),
        .wr_addr (prev_reg),
        .wr_row  (mx_wrow)
    );

    assign id_node         = LW'(id_reg);
    assign id_out_of_range = (32'(id_reg) >= MAX_LOCKS);
    assign count_m1        = held_count_reg - HCW'(1);
    assign hs_raddr        = count_m1[SW-1:0];
    assign walk_raddr      = LW'(sp_reg - CW'(1));
    assign mx_wrow         = mx_row | (MAX_LOCKS'(1) << id_node);

    // neighbors at or above the cursor of the node on top of the walk
    always_comb begin
        for (int i = 0; i < MAX_LOCKS; i++) begin
            avail[i] = mx_row[i] && (CW'(i) >= top_cur_reg);
        end
    end

    always_comb begin
        t_found = 1'b0;
        t_idx   = '0;
        r_found = 1'b0;
        r_idx   = '0;
        for (int i = MAX_LOCKS - 1; i >= 0; i--) begin
            if (avail[i]) begin
                t_found = 1'b1;
                t_idx   = LW'(i);
            end
            if (!seen_reg[i]) begin
                r_found = 1'b1;
                r_idx   = LW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (hs_we) begin
            held_mem[held_count_reg[SW-1:0]] <= id_reg;
        end
        hs_rdata_reg <= held_mem[hs_raddr];
        if (walk_we) begin
            walk_mem[sp_reg[LW-1:0]] <= walk_wdata;
        end
        walk_rdata_reg <= walk_mem[walk_raddr];
    end

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        held_count_next = held_count_reg;
        halted_next     = halted_reg;
        prev_next       = prev_reg;
        seen_next       = seen_reg;
        done_next       = done_reg;
        top_node_next   = top_node_reg;
        top_cur_next    = top_cur_reg;
        sp_next         = sp_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        hs_we           = 1'b0;
        walk_we         = 1'b0;
        walk_wdata      = '{node: top_node_reg, cur: CW'(t_idx) + CW'(1)};
        mx_we           = 1'b0;
        mx_raddr        = top_node_reg;
        s_ready         = (state_reg == S_IDLE);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_data.kind;
                    id_next    = s_data.lock_id;
                    state_next = S_TOP;
                end
            end
            S_TOP: begin
                res_next   = '{status: ST_OK, cycle_from: '0, cycle_to: '0,
                               held_depth: '0};
                prev_next  = LW'(hs_rdata_reg);
                mx_raddr   = LW'(hs_rdata_reg);
                state_next = S_OUT;
                priority if (halted_reg) begin
                    res_next.status = ST_HALTED;
                end else if (id_out_of_range) begin
                    res_next.status = ST_OK;
                end else if (kind_reg == KIND_RELEASE) begin
                    if (held_count_reg == '0) begin
                        res_next.status = ST_MULTI_UNLOCK;
                        halted_next     = 1'b1;
                    end else if (hs_rdata_reg != id_reg) begin
                        res_next.status = ST_BAD_UNLOCK;
                        halted_next     = 1'b1;
                    end else begin
                        held_count_next = count_m1;
                    end
                end else if (32'(held_count_reg) >= STACK_DEPTH) begin
                    res_next.status = ST_OVERFLOW;
                    halted_next     = 1'b1;
                end else if (held_count_reg == '0 || hs_rdata_reg == id_reg) begin
                    hs_we           = 1'b1;
                    held_count_next = held_count_reg + HCW'(1);
                end else begin
                    state_next = S_EDGE;
                end
            end
            S_EDGE: begin
                if (mx_row[id_node]) begin
                    hs_we           = 1'b1;
                    held_count_next = held_count_reg + HCW'(1);
                    state_next      = S_OUT;
                end else begin
                    mx_we      = 1'b1;
                    seen_next  = '0;
                    done_next  = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT: begin
                mx_raddr = r_idx;
                if (r_found) begin
                    seen_next[r_idx] = 1'b1;
                    top_node_next    = r_idx;
                    top_cur_next     = '0;
                    sp_next          = '0;
                    state_next       = S_SCAN;
                end else begin
                    res_next.status = ST_NEW_EDGE;
                    hs_we           = 1'b1;
                    held_count_next = held_count_reg + HCW'(1);
                    state_next      = S_OUT;
                end
            end
            S_SCAN: begin
                if (!t_found) begin
                    done_next[top_node_reg] = 1'b1;
                    if (sp_reg == '0) begin
                        state_next = S_ROOT;
                    end else begin
                        sp_next    = sp_reg - CW'(1);
                        state_next = S_POP;
                    end
                end else if (!seen_reg[t_idx]) begin
                    walk_we          = 1'b1;
                    sp_next          = sp_reg + CW'(1);
                    seen_next[t_idx] = 1'b1;
                    top_node_next    = t_idx;
                    top_cur_next     = '0;
                    mx_raddr         = t_idx;
                end else if (!done_reg[t_idx]) begin
                    // target still on the walk: back edge
                    res_next.status     = ST_DEADLOCK;
                    res_next.cycle_from = 5'(top_node_reg);
                    res_next.cycle_to   = 5'(t_idx);
                    halted_next         = 1'b1;
                    state_next          = S_OUT;
                end else begin
                    top_cur_next = CW'(t_idx) + CW'(1);
                end
            end
            S_POP: begin
                top_node_next = walk_rdata_reg.node;
                top_cur_next  = walk_rdata_reg.cur;
                mx_raddr      = walk_rdata_reg.node;
                state_next    = S_SCAN;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next            = res_reg;
                    m_data_next.held_depth = 5'(held_count_reg);
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            held_count_reg <= '0;
            halted_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            halted_reg     <= halted_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        id_reg       <= id_next;
        prev_reg     <= prev_next;
        seen_reg     <= seen_next;
        done_reg     <= done_next;
        top_node_reg <= top_node_next;
        top_cur_reg  <= top_cur_next;
        sp_reg       <= sp_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the lock order cycle checker: directed, random and fault lock traffic, predicted and scoreboarded.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lococ_pkg::*;

    localparam int NUM_LOCKS   = 32;
    localparam int HOLD_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 870;
    localparam int IDLE_LIMIT  = 20000;

    typedef enum int {
        FAULT_CYCLE, FAULT_OVERFLOW, FAULT_EMPTY_RELEASE, FAULT_WRONG_RELEASE
    } fault_e;

    class lock_scoreboard;
        logic [31:0]   edges [NUM_LOCKS];
        logic [4:0]    held [HOLD_DEPTH];
        int            depth;
        bit            stopped;
        lococ_out_t    pending [$];
        int            errors;

        function new();
            foreach (edges[i]) edges[i] = '0;
            depth = 0;
            stopped = 0;
            errors = 0;
        endfunction

        // true if dst is reachable from src over the order edges
        function bit reaches(int src, int dst);
            logic [31:0] r;
            r = 32'd1 << src;
            repeat (NUM_LOCKS) begin
                for (int i = 0; i < NUM_LOCKS; i++) begin
                    if (r[i]) r |= edges[i];
                end
            end
            return r[dst];
        endfunction

        // depth-first search, roots and neighbours in ascending id order
        function bit find_back_edge(output logic [4:0] src, output logic [4:0] dst);
            logic [31:0] seen;
            logic [31:0] finished;
            int rank [NUM_LOCKS];
            int cursor [NUM_LOCKS];
            int walk [NUM_LOCKS];
            int sp;
            int order;
            int h;
            int t;
            seen = '0;
            finished = '0;
            order = 0;
            src = '0;
            dst = '0;
            foreach (rank[i]) begin
                rank[i] = 0;
                cursor[i] = 0;
            end
            for (int root = 0; root < NUM_LOCKS; root++) begin
                if (seen[root]) continue;
                seen[root] = 1'b1;
                rank[root] = order++;
                cursor[root] = 0;
                sp = 0;
                walk[sp++] = root;
                while (sp > 0) begin
                    h = walk[sp-1];
                    t = cursor[h];
                    while (t < NUM_LOCKS && !edges[h][t]) t++;
                    if (t >= NUM_LOCKS) begin
                        finished[h] = 1'b1;
                        sp--;
                        continue;
                    end
                    cursor[h] = t + 1;
                    if (!seen[t]) begin
                        seen[t] = 1'b1;
                        rank[t] = order++;
                        cursor[t] = 0;
                        if (sp < NUM_LOCKS) walk[sp++] = t;
                        continue;
                    end
                    if (rank[h] < rank[t]) continue;
                    if (!finished[t]) begin
                        src = h[4:0];
                        dst = t[4:0];
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void note_event(lococ_in_t ev);
            lococ_out_t res;
            int prev;
            bit push;
            res = '0;
            if (stopped) begin
                res.status = ST_HALTED;
            end else if (ev.kind == KIND_ACQUIRE) begin
                if (depth >= HOLD_DEPTH) begin
                    res.status = ST_OVERFLOW;
                    stopped = 1;
                end else begin
                    push = 1;
                    if (depth > 0) begin
                        prev = held[depth-1];
                        if (prev != ev.lock_id && !edges[prev][ev.lock_id]) begin
                            edges[prev][ev.lock_id] = 1'b1;
                            if (find_back_edge(res.cycle_from, res.cycle_to)) begin
                                res.status = ST_DEADLOCK;
                                stopped = 1;
                                push = 0;
                            end else begin
                                res.status = ST_NEW_EDGE;
                            end
                        end
                    end
                    if (push) held[depth++] = ev.lock_id;
                end
            end else begin
                if (depth == 0) begin
                    res.status = ST_MULTI_UNLOCK;
                    stopped = 1;
                end else if (held[depth-1] != ev.lock_id) begin
                    res.status = ST_BAD_UNLOCK;
                    stopped = 1;
                end else begin
                    depth--;
                end
            end
            res.held_depth = depth[4:0];
            pending.push_back(res);
        endfunction

        function void check_result(lococ_out_t got);
            lococ_out_t exp;
            if (pending.size() == 0) begin
                $error("unexpected result transaction %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.cycle_from !== exp.cycle_from) begin
                $error("cycle_from: expected %0d, got %0d", exp.cycle_from, got.cycle_from);
                errors++;
            end
            if (got.cycle_to !== exp.cycle_to) begin
                $error("cycle_to: expected %0d, got %0d", exp.cycle_to, got.cycle_to);
                errors++;
            end
            if (got.held_depth !== exp.held_depth) begin
                $error("held_depth: expected %0d, got %0d", exp.held_depth, got.held_depth);
                errors++;
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    lococ_in_t  s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    lococ_out_t m_data;

    lock_scoreboard sb = new();
    int  idle_cycles = 0;
    int  results_seen = 0;

    always #1 aclk = ~aclk;

    lock_order_cycle_checker_top #(.MAX_LOCKS(NUM_LOCKS), .STACK_DEPTH(HOLD_DEPTH)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_event(logic kind, logic [4:0] id);
        int gap;
        lococ_in_t ev;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        ev.kind = kind;
        ev.lock_id = id;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
        sb.note_event(ev);
        @(negedge aclk);
    endtask

    task automatic acquire(logic [4:0] id);
        send_event(KIND_ACQUIRE, id);
    endtask

    task automatic release_top();
        send_event(KIND_RELEASE, sb.held[sb.depth-1]);
    endtask

    // once halted the depth no longer drops
    task automatic release_all();
        while (sb.depth > 0 && !sb.stopped) release_top();
    endtask

    // acquire that never closes a cycle in the order graph
    task automatic random_acquire();
        logic [4:0] id;
        int top;
        id = 5'($urandom_range(0, NUM_LOCKS - 1));
        if (sb.depth > 0) begin
            top = sb.held[sb.depth-1];
            if ($urandom_range(0, 6) == 0) id = top[4:0];
            for (int k = 0; k < 20 && id != top && sb.reaches(id, top); k++)
                id = 5'($urandom_range(0, NUM_LOCKS - 1));
            if (id != top && sb.reaches(id, top)) id = top[4:0];
        end
        acquire(id);
    endtask

    initial begin
        fault_e fault;
        logic [4:0] a;
        logic [4:0] b;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: id extremes, new and known edges, repeated acquire, a full stack
        acquire(5'd0);
        acquire(5'd31);
        acquire(5'd31);
        release_top();
        release_top();
        acquire(5'd31);
        release_top();
        acquire(5'd31);
        acquire(5'd21);
        acquire(5'd10);
        release_top();
        release_top();
        release_top();
        release_top();
        for (int i = 0; i < HOLD_DEPTH; i++) acquire(5'd12);
        release_all();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (sb.depth == HOLD_DEPTH) release_top();
            else if (sb.depth == 0) random_acquire();
            else if ($urandom_range(0, 9) < 6) random_acquire();
            else release_top();
        end

        // one terminal fault, then events that must be refused
        release_all();
        fault = fault_e'($urandom_range(0, 3));
        case (fault)
            FAULT_CYCLE: begin
                a = 5'($urandom_range(0, 30));
                b = 5'($urandom_range(a + 1, 31));
                acquire(a);
                acquire(b);
                release_all();
                acquire(b);
                acquire(a);
            end
            FAULT_OVERFLOW: begin
                for (int i = 0; i <= HOLD_DEPTH; i++) acquire(5'd7);
            end
            FAULT_EMPTY_RELEASE: begin
                send_event(KIND_RELEASE, 5'($urandom_range(0, 31)));
            end
            default: begin
                a = 5'($urandom_range(0, 31));
                acquire(a);
                send_event(KIND_RELEASE, a ^ 5'($urandom_range(1, 31)));
            end
        endcase
        for (int i = 0; i < 5; i++)
            send_event(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
        s_valid <= 1'b0;

        while (sb.pending.size() > 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // result side: random stalls plus one long hold-off to back the block up
    initial begin
        int stall;
        @(negedge aclk);
        forever begin
            stall = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (results_seen == 150) stall = 600;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_valid));
            sb.check_result(m_data);
            results_seen++;
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule

// ----- filelist.f -----
src/lococ_pkg.sv
src/lococ_matrix.sv
src/lock_order_cycle_checker_top.sv
verif/tb_top.sv
